// ===== rtl/core/ip_range_to_cidr_blocks_top_macros.svh =====
// Assertion macros for the range-to-CIDR block checker.
// Used by the checker bound to ip_range_to_cidr_blocks_top; expects clock and reset in scope.
`ifndef IP_RANGE_TO_CIDR_BLOCKS_TOP_MACROS_SVH
`define IP_RANGE_TO_CIDR_BLOCKS_TOP_MACROS_SVH

// same-cycle implication
`define IRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/irc_pkg.sv =====
// Shared types, widths and helpers for the range-to-CIDR block.
// No dependencies; used by every module under rtl/core.
package irc_pkg;

   localparam int AddrWidth    = 32;
   localparam int CountWidth   = 33;
   localparam int ReqDataWidth = 72;  // 65 bits of fields, padded to bytes
   localparam int RspDataWidth = 40;  // 38 bits of fields, padded to bytes
   localparam int LogWidth     = 6;

   localparam logic [CountWidth-1:0] FullSpace = 33'h1_0000_0000;
   localparam logic [LogWidth-1:0]   PrefixMax = 6'd32;

   typedef struct packed {
      logic [AddrWidth-1:0]  addr;
      logic [CountWidth-1:0] remain;
   } irc_job_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic        valid;
      irc_job_type job;
   } irc_head_type;

   // bit index of a one-hot value
   function automatic logic [LogWidth-1:0] onehot_log2(input logic [CountWidth-1:0] v);
      logic [LogWidth-1:0] r;
      r = '0;
      for (int i = 0; i < CountWidth; i++) begin
         if (v[i]) begin
            r = r | LogWidth'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/irc_front.sv =====
// Front end: takes request items, saturates the count and drops empty ranges.
// Depends on irc_pkg; feeds irc_queue.
module irc_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [irc_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic                             queue_full,
   output logic                             push,
   output irc_pkg::irc_job_type             push_job
);

   logic [irc_pkg::CountWidth-1:0] count;

   assign count      = req_tdata[irc_pkg::AddrWidth +: irc_pkg::CountWidth];
   assign req_tready = !queue_full;

   always_comb begin
      push_job.addr   = req_tdata[irc_pkg::AddrWidth-1:0];
      // anything above the full address space covers it exactly once
      push_job.remain = (count > irc_pkg::FullSpace) ? irc_pkg::FullSpace : count;
      // a zero count is accepted and produces nothing
      push            = req_tvalid && !queue_full && (count != '0);
   end

endmodule

// ===== rtl/core/irc_queue.sv =====
// Two-entry job queue between front and back end.
// Depends on irc_pkg.
module irc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  irc_pkg::irc_job_type push_job,
   input  logic                 pop,
   output logic                 full,
   output irc_pkg::irc_head_type head
);

   logic                 v0_ff, v0_in, v1_ff, v1_in;
   irc_pkg::irc_job_type e0_ff, e0_in, e1_ff, e1_in;

   assign full       = v0_ff && v1_ff;
   assign head.valid = v0_ff;
   assign head.job   = e0_ff;

   always_comb begin
      v0_in = v0_ff;
      v1_in = v1_ff;
      e0_in = e0_ff;
      e1_in = e1_ff;
      if (pop && push) begin
         if (v1_ff) begin
            e0_in = e1_ff;
            e1_in = push_job;
         end else begin
            e0_in = push_job;
         end
      end else if (pop) begin
         e0_in = e1_ff;
         v0_in = v1_ff;
         v1_in = 1'b0;
      end else if (push) begin
         if (!v0_ff) begin
            e0_in = push_job;
            v0_in = 1'b1;
         end else begin
            e1_in = push_job;
            v1_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

endmodule

// ===== rtl/core/irc_back.sv =====
// Back end: splits a range into CIDR blocks held in a result register, one block per cycle
// while the result is not stalled. Depends on irc_pkg; takes jobs from irc_queue.
module irc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  irc_pkg::irc_head_type            head,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [irc_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic                             rsp_tlast
);

   logic                            busy_ff, busy_in;
   logic [irc_pkg::AddrWidth-1:0]   addr_ff, addr_in;
   logic [irc_pkg::CountWidth-1:0]  remain_ff, remain_in;
   logic                            valid_ff, valid_in;
   logic [irc_pkg::AddrWidth-1:0]   base_ff, base_in;
   logic [irc_pkg::LogWidth-1:0]    prefix_ff, prefix_in;
   logic                            last_ff, last_in;

   logic [irc_pkg::CountWidth-1:0]  low_bit, smear, top_bit, size, remain_next;
   logic                            step, done;

   always_comb begin
      // lowest set bit of the address; zero address stands for the whole space
      low_bit = {addr_ff == '0, addr_ff & (~addr_ff + 32'd1)};
      // ones at and below the top bit of the remaining count
      smear = remain_ff;
      smear = smear | (smear >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      smear = smear | (smear >> 16);
      smear = smear | (smear >> 32);
      top_bit = smear & ~(smear >> 1);
      size    = ((low_bit & smear) != '0) ? low_bit : top_bit;
      remain_next = remain_ff - size;

      step = busy_ff && (!valid_ff || rsp_tready);
      done = step && (remain_next == '0);
      pop  = head.valid && (!busy_ff || done);

      busy_in   = busy_ff;
      addr_in   = addr_ff;
      remain_in = remain_ff;
      if (pop) begin
         busy_in   = 1'b1;
         addr_in   = head.job.addr;
         remain_in = head.job.remain;
      end else if (step) begin
         busy_in   = !done;
         addr_in   = addr_ff + size[irc_pkg::AddrWidth-1:0];
         remain_in = remain_next;
      end

      valid_in  = valid_ff;
      base_in   = base_ff;
      prefix_in = prefix_ff;
      last_in   = last_ff;
      if (step) begin
         valid_in  = 1'b1;
         base_in   = addr_ff;
         prefix_in = irc_pkg::PrefixMax - irc_pkg::onehot_log2(size);
         last_in   = remain_next == '0;
      end else if (rsp_tready) begin
         valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      remain_ff <= remain_in;
      base_ff   <= base_in;
      prefix_ff <= prefix_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {2'b00, prefix_ff, base_ff};

endmodule

// ===== rtl/core/ip_range_to_cidr_blocks_top.sv =====
// Range-to-CIDR block: one request item (start address, count) in, a run of
// CIDR blocks out, ascending from the start address and wrapping past the top,
// tlast on the final block. A front end drops zero-count items and saturates
// counts above 2^32, then queues the range in a two-entry queue; the back end
// emits one block per cycle while the result is not stalled, 1 to 62 blocks per
// item, from its address/count update loop. The next queued range is popped
// in the same cycle as the last block of the previous one is registered, and a
// new request is taken every cycle while the queue has room.
// Depends on irc_pkg, irc_front, irc_queue and irc_back.
module ip_range_to_cidr_blocks_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // bits: start_address [31:0], range_count [64:32], zero [71:65]
   input  logic [irc_pkg::ReqDataWidth-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // bits: block_base [31:0], prefix_length [37:32], zero [39:38]
   output logic [irc_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic                             rsp_tlast   // last_block
);

   logic                  push, queue_full, pop;
   irc_pkg::irc_job_type  push_job;
   irc_pkg::irc_head_type head;

   irc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   irc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .head     (head)
   );

   irc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/irc_checker.sv =====
// Port-level checker for ip_range_to_cidr_blocks_top, bound to the top level.
// Depends on irc_pkg and ip_range_to_cidr_blocks_top_macros.svh.
`include "ip_range_to_cidr_blocks_top_macros.svh"

module irc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [irc_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   logic [irc_pkg::AddrWidth-1:0] base, host_mask;
   logic [irc_pkg::LogWidth-1:0]  prefix;
   logic                          rsp_take;
   logic                          pend_ff, pend_in;
   logic [irc_pkg::AddrWidth-1:0] next_ff, next_in;

   assign base      = rsp_tdata[irc_pkg::AddrWidth-1:0];
   assign prefix    = rsp_tdata[irc_pkg::AddrWidth +: irc_pkg::LogWidth];
   assign host_mask = 32'hFFFF_FFFF >> prefix;
   assign rsp_take  = rsp_tvalid && rsp_tready;

   // expected base of the following block within a range
   always_comb begin
      pend_in = pend_ff;
      next_in = next_ff;
      if (rsp_take) begin
         pend_in = !rsp_tlast;
         next_in = base + host_mask + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff <= next_in;
   end

   `IRC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")
   `IRC_ASSERT_NOW(a_prefix_range, rsp_tvalid, prefix <= irc_pkg::PrefixMax && rsp_tdata[39:38] == 2'b00, "bad prefix or padding")
   `IRC_ASSERT_NOW(a_aligned, rsp_tvalid, (base & host_mask) == '0, "block base not aligned")
   `IRC_ASSERT_NOW(a_contiguous, rsp_take && pend_ff, base == next_ff, "gap between blocks")

endmodule

bind ip_range_to_cidr_blocks_top irc_checker u_irc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== sim/ip_range_to_cidr_blocks_top_tb.sv =====
// Self-checking testbench for ip_range_to_cidr_blocks_top: drives address ranges,
// predicts the CIDR block run of each one and checks every block that comes out.
// Depends on irc_pkg and the RTL under rtl/core.
module ip_range_to_cidr_blocks_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 400000;
   localparam int MaxBlocks  = 64;
   localparam int DrainWait  = 80;
   localparam int LongHold   = 300;

   typedef struct packed {
      logic [irc_pkg::AddrWidth-1:0] base;
      logic [irc_pkg::LogWidth-1:0]  prefix;
      logic                          last;
   } cidr_block_type;

   class cidr_scoreboard_type;
      cidr_block_type want_q[$];
      int             errors;

      function new();
         errors = 0;
      endfunction

      task report(input string what);
         $display("[%0t] MISMATCH: %s", $realtime, what);
         errors++;
      endtask

      // expand one accepted range into the blocks it must produce
      function void note_range(input logic [irc_pkg::AddrWidth-1:0]  start,
                               input logic [irc_pkg::CountWidth-1:0] cnt);
         logic [irc_pkg::CountWidth-1:0] left;
         logic [irc_pkg::CountWidth-1:0] size;
         logic [irc_pkg::AddrWidth-1:0]  cur;
         int                             lg;
         int                             n;
         cidr_block_type                 blk;
         left = (cnt > irc_pkg::FullSpace) ? irc_pkg::FullSpace : cnt;
         cur  = start;
         n    = 0;
         while (left != 0 && n < MaxBlocks) begin
            if (cur == '0) size = irc_pkg::FullSpace;
            else size = {1'b0, cur & (~cur + 32'd1)};
            while (size > left) size = size >> 1;
            lg = 0;
            for (int i = 0; i < irc_pkg::CountWidth; i++) if (size[i]) lg = i;
            left       = left - size;
            blk.base   = cur;
            blk.prefix = irc_pkg::LogWidth'(32 - lg);
            blk.last   = (left == 0);
            want_q.insert(want_q.size(), blk);
            cur = cur + size[irc_pkg::AddrWidth-1:0];
            n++;
         end
      endfunction

      task check_block(input logic [irc_pkg::AddrWidth-1:0] base,
                       input logic [irc_pkg::LogWidth-1:0] prefix,
                       input logic last);
         cidr_block_type want;
         if (want_q.size() == 0) begin
            report($sformatf("unexpected block %h/%0d last=%b", base, prefix, last));
            return;
         end
         want = want_q.pop_front();
         if (base !== want.base)
            report($sformatf("base %h, expected %h", base, want.base));
         if (prefix !== want.prefix)
            report($sformatf("prefix %0d at %h, expected %0d", prefix, want.base, want.prefix));
         if (last !== want.last)
            report($sformatf("tlast %b at %h, expected %b", last, want.base, want.last));
      endtask

      function int pending();
         return want_q.size();
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [irc_pkg::ReqDataWidth-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [irc_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                             rsp_tlast;

   cidr_scoreboard_type sb = new();
   bit                  tx_idle;
   bit                  rx_idle;
   bit                  hold_req;
   bit                  rx_running;
   int                  cycles;

   ip_range_to_cidr_blocks_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CycleLimit) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_block(rsp_tdata[31:0], rsp_tdata[37:32], rsp_tlast);
   end

   // result side: random stall per item while rx_idle is set, one long hold-off on request
   initial begin
      int stall;
      wait (rx_running);
      forever begin
         stall = rx_idle ? $urandom_range(0, 7) : 0;
         if (hold_req) begin
            stall    = LongHold;
            hold_req = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_range(input logic [irc_pkg::AddrWidth-1:0]  start,
                             input logic [irc_pkg::CountWidth-1:0] cnt);
      int gap;
      gap = tx_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, cnt, start};
      do @(posedge clock); while (!req_tready);
      sb.note_range(start, cnt);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random_range();
      logic [irc_pkg::AddrWidth-1:0]  start;
      logic [irc_pkg::CountWidth-1:0] cnt;
      int                             k;
      case ($urandom_range(0, 3))
         0: start = $urandom();
         1: begin
            k     = $urandom_range(0, 31);
            start = $urandom() & ~((32'd1 << k) - 32'd1);
         end
         2: start = 32'hFFFF_FFFF - $urandom_range(0, 300);
         default: start = $urandom_range(0, 1023);
      endcase
      case ($urandom_range(0, 9)) inside
         0: cnt = '0;
         [1:3]: cnt = irc_pkg::CountWidth'($urandom_range(1, 64));
         4: cnt = irc_pkg::CountWidth'(1) << $urandom_range(0, 32);
         5: cnt = {1'($urandom_range(0, 1)), $urandom()};
         6: cnt = irc_pkg::FullSpace;
         default: cnt = {1'b0, $urandom()};
      endcase
      send_range(start, cnt);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      tx_idle    = 1'b1;
      rx_idle    = 1'b1;
      hold_req   = 1'b0;
      rx_running = 1'b0;
      repeat (7) @(posedge clock);
      reset      <= 1'b0;
      rx_running = 1'b1;

      // directed: zero counts, extremes, saturation and wrap past the top
      send_range(32'h0000_0000, 33'd0);
      send_range(32'h0A00_0000, 33'd0);
      send_range(32'h0000_0000, 33'd1);
      send_range(32'hFFFF_FFFF, 33'd1);
      send_range(32'h0000_0000, irc_pkg::FullSpace);
      send_range(32'h0000_0001, irc_pkg::FullSpace);
      send_range(32'hFFFF_FFFF, irc_pkg::FullSpace);
      send_range(32'h0000_0000, 33'h1_FFFF_FFFF);
      send_range(32'h8000_0000, 33'h1_8000_0000);
      send_range(32'hFFFF_FFF0, 33'd32);
      send_range(32'hFFFF_FFFF, 33'd2);
      send_range(32'hC0A8_0001, 33'd256);
      send_range(32'hC0A8_0000, 33'd256);
      send_range(32'h0000_0001, 33'h0_FFFF_FFFF);
      send_range(32'hAAAA_AAAA, 33'h0_5555_5555);
      send_range(32'h5555_5555, 33'h0_AAAA_AAAA);
      send_range(32'h1234_5678, 33'd1000);
      send_range(32'hFFFF_0000, 33'd65536);
      send_range(32'h7FFF_FFFF, 33'd2);

      // sender pauses until everything is back
      req_tvalid <= 1'b0;
      wait_drained();

      // long receiver hold-off while the sender keeps offering items
      tx_idle  = 1'b0;
      hold_req = 1'b1;
      for (int i = 0; i < 10; i++)
         send_range($urandom(), irc_pkg::CountWidth'($urandom_range(1, 20)));
      tx_idle = 1'b1;

      for (int i = 0; i < 120; i++) begin
         if (i % 25 == 0) begin
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
         end
         send_random_range();
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (DrainWait) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/irc_pkg.sv
rtl/core/irc_front.sv
rtl/core/irc_queue.sv
rtl/core/irc_back.sv
rtl/core/ip_range_to_cidr_blocks_top.sv
rtl/core/irc_checker.sv
sim/ip_range_to_cidr_blocks_top_tb.sv
